// ===== src/open_address_hash_table_defines.svh =====
// Assertion macros for the open-address hash table
`ifndef OPEN_ADDRESS_HASH_TABLE_DEFINES_SVH
`define OPEN_ADDRESS_HASH_TABLE_DEFINES_SVH

// Check an implication on every clock edge outside reset
`define OAHT_ASSERT_IMPL(label, cond, expect_expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expect_expr)) \
    else $error(msg);

// Check an implication in the cycle after the condition
`define OAHT_ASSERT_NEXT(label, cond, expect_expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expect_expr)) \
    else $error(msg);

`endif

// ===== src/oaht_pkg.sv =====
// Package with codes and types for the open-address hash table
package oaht_pkg;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_PUT    = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    MARK_OPEN = 2'd0,
    MARK_USED = 2'd1,
    MARK_TOMB = 2'd2,
    MARK_RSVD = 2'd3
  } mark_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_DONE
  } state_t;

  localparam int HASH_BITS  = 32;
  localparam int SLOT_BITS  = 8;
  localparam int COUNT_BITS = 9;
  localparam logic [COUNT_BITS-1:0] LIMIT_RESET = 9'd256;

endpackage

// ===== src/oaht_if.sv =====
// Request and response channel interfaces
interface oaht_req_if #(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            action;
  logic [KEY_BITS-1:0]   key;
  logic [31:0]           key_hash;
  logic [VALUE_BITS-1:0] write_value;

  modport source (output valid, action, key, key_hash, write_value, input ready);
  modport sink   (input valid, action, key, key_hash, write_value, output ready);
endinterface

interface oaht_rsp_if #(
  parameter int VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic                  found;
  logic                  inserted;
  logic                  table_full;
  logic [7:0]            slot_index;
  logic [VALUE_BITS-1:0] read_value;
  logic [8:0]            entry_count;

  modport source (output valid, found, inserted, table_full, slot_index, read_value,
                  entry_count, input ready);
  modport sink   (input valid, found, inserted, table_full, slot_index, read_value,
                  entry_count, output ready);
endinterface

// ===== src/open_address_hash_table.sv =====
// Open-address hash table: one probe sequencer over slot memories.
// A new word is accepted only in the idle state, once the previous result word has been
//   registered, which waits while the output still holds an untaken result; a lookup or
//   remove on an empty table, or an unknown action, needs no probe.
// Reset: synchronous; a clearing pass marks all CAPACITY slots open, one per cycle,
//   and no word is accepted during the pass. entry_limit resets to 256.
`include "open_address_hash_table_defines.svh"

module open_address_hash_table
  import oaht_pkg::*;
#(
  parameter int CAPACITY         = 256,
  parameter int KEY_BITS         = 32,
  parameter int VALUE_BITS       = 32,
  parameter int FINGERPRINT_BITS = 7
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [COUNT_BITS-1:0] cfg_wdata,
  oaht_req_if.sink              req,
  oaht_rsp_if.source            rsp
);

  localparam int PW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int LW  = (CW > COUNT_BITS) ? CW : COUNT_BITS;
  localparam int SXW = (PW > SLOT_BITS) ? PW : SLOT_BITS;
  localparam int MW  = 2 + FINGERPRINT_BITS;

  // Slot memories
  logic [MW-1:0]         meta_mem  [CAPACITY];
  logic [KEY_BITS-1:0]   key_mem   [CAPACITY];
  logic [VALUE_BITS-1:0] value_mem [CAPACITY];
  logic [MW-1:0]         meta_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;

  state_t state, state_next;
  logic [COUNT_BITS-1:0] entry_limit;
  logic [CW-1:0]         used_count;
  logic [PW-1:0]         clr_idx;
  logic [PW-1:0]         pos;
  logic [PW-1:0]         probe_n;
  logic                  tomb_seen;
  logic [PW-1:0]         tomb_pos;

  // Request capture
  action_t                      act;
  logic [KEY_BITS-1:0]          req_key;
  logic [FINGERPRINT_BITS-1:0]  req_fp;
  logic [VALUE_BITS-1:0]        req_val;

  // Result staging
  logic                  res_found;
  logic                  res_inserted;
  logic                  res_full;
  logic [PW-1:0]         res_slot;
  logic [VALUE_BITS-1:0] res_value;

  // Probe decisions
  mark_t                       cur_mark;
  logic [FINGERPRINT_BITS-1:0] cur_fp;
  logic                        is_open, is_tomb, is_hit, is_last, end_miss;
  logic                        have_free, at_limit;
  logic [PW-1:0]               free_slot;
  logic [LW-1:0]               count_ext, limit_ext, lim_eff;
  logic                        accept, early_done, rsp_free;

  // Memory write controls
  logic              meta_we, key_we, value_we;
  logic [PW-1:0]     wr_addr;
  logic [MW-1:0]     meta_wdata;

  logic [SXW-1:0] slot_ext;

  assign accept   = req.valid && req.ready;
  assign rsp_free = !rsp.valid || rsp.ready;

  assign cur_mark = mark_t'(meta_q[MW-1 -: 2]);
  assign cur_fp   = meta_q[FINGERPRINT_BITS-1:0];
  assign is_open  = (cur_mark == MARK_OPEN);
  assign is_tomb  = (cur_mark == MARK_TOMB);
  assign is_hit   = (cur_mark == MARK_USED) && (cur_fp == req_fp) && (key_q == req_key);
  assign is_last  = (probe_n == {PW{1'b1}});
  assign end_miss = is_open || (!is_hit && is_last);

  assign have_free = is_open || is_tomb || tomb_seen;
  assign free_slot = tomb_seen ? tomb_pos : pos;

  assign count_ext = LW'(used_count);
  assign limit_ext = LW'(entry_limit);
  assign lim_eff   = (limit_ext < LW'(CAPACITY)) ? limit_ext : LW'(CAPACITY);
  assign at_limit  = (count_ext >= lim_eff);

  assign early_done = (action_t'(req.action) == ACT_NONE) ||
                      ((action_t'(req.action) != ACT_PUT) && (used_count == '0));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_idx == {PW{1'b1}}) state_next = ST_IDLE;
      ST_IDLE:  if (accept) state_next = early_done ? ST_DONE : ST_READ;
      ST_READ:  state_next = ST_CHECK;
      ST_CHECK: if (is_hit || end_miss) state_next = ST_DONE;
                else state_next = ST_READ;
      ST_DONE:  if (rsp_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake and memory writes
  always_comb begin
    req.ready  = (state == ST_IDLE);
    meta_we    = 1'b0;
    key_we     = 1'b0;
    value_we   = 1'b0;
    wr_addr    = pos;
    meta_wdata = {MARK_USED, req_fp};
    case (state)
      ST_CLEAR: begin
        meta_we    = 1'b1;
        wr_addr    = clr_idx;
        meta_wdata = {MARK_OPEN, {FINGERPRINT_BITS{1'b0}}};
      end
      ST_CHECK: begin
        if (is_hit && act == ACT_PUT) begin
          value_we = 1'b1;
        end else if (is_hit && act == ACT_REMOVE) begin
          meta_we    = 1'b1;
          meta_wdata = {MARK_TOMB, cur_fp};
        end else if (!is_hit && end_miss && act == ACT_PUT && have_free && !at_limit) begin
          meta_we  = 1'b1;
          key_we   = 1'b1;
          value_we = 1'b1;
          wr_addr  = free_slot;
        end
      end
      default: ;
    endcase
  end

  // Memory ports: one write, registered read at the probe position
  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[wr_addr] <= meta_wdata;
    meta_q <= meta_mem[pos];
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[wr_addr] <= req_key;
    key_q <= key_mem[pos];
  end

  always_ff @(posedge clk) begin
    if (value_we) value_mem[wr_addr] <= req_val;
    value_q <= value_mem[pos];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_idx     <= '0;
      used_count  <= '0;
      entry_limit <= LIMIT_RESET;
      rsp.valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) entry_limit <= cfg_wdata;
      if (state == ST_CLEAR) clr_idx <= clr_idx + 1'b1;
      if (state == ST_CHECK && is_hit && act == ACT_REMOVE) begin
        used_count <= used_count - 1'b1;
      end else if (key_we) begin
        used_count <= used_count + 1'b1;
      end
      if (state == ST_DONE && rsp_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Probe walk and result staging
  always_ff @(posedge clk) begin
    if (accept) begin
      act          <= action_t'(req.action);
      req_key      <= req.key;
      req_fp       <= req.key_hash[HASH_BITS-1 -: FINGERPRINT_BITS];
      req_val      <= req.write_value;
      pos          <= req.key_hash[PW-1:0];
      probe_n      <= '0;
      tomb_seen    <= 1'b0;
      tomb_pos     <= '0;
      res_found    <= 1'b0;
      res_inserted <= 1'b0;
      res_full     <= 1'b0;
      res_slot     <= '0;
      res_value    <= '0;
    end else if (state == ST_CHECK) begin
      if (is_hit) begin
        res_found <= 1'b1;
        res_slot  <= pos;
        if (act == ACT_LOOKUP) res_value <= value_q;
      end else if (end_miss) begin
        if (act == ACT_PUT) begin
          if (have_free && !at_limit) begin
            res_inserted <= 1'b1;
            res_slot     <= free_slot;
          end else begin
            res_full <= 1'b1;
          end
        end
      end else begin
        // advance to the next slot, remembering the first tombstone
        if (is_tomb && !tomb_seen) begin
          tomb_seen <= 1'b1;
          tomb_pos  <= pos;
        end
        pos     <= pos + 1'b1;
        probe_n <= probe_n + 1'b1;
      end
    end
  end

  assign slot_ext = SXW'(res_slot);

  // Output word register
  always_ff @(posedge clk) begin
    if (state == ST_DONE && rsp_free) begin
      rsp.found       <= res_found;
      rsp.inserted    <= res_inserted;
      rsp.table_full  <= res_full;
      rsp.slot_index  <= slot_ext[SLOT_BITS-1:0];
      rsp.read_value  <= res_value;
      rsp.entry_count <= count_ext[COUNT_BITS-1:0];
    end
  end

  `OAHT_ASSERT_IMPL(a_count_bound, 1'b1, count_ext <= LW'(CAPACITY), "used count above capacity")
  `OAHT_ASSERT_IMPL(a_rsp_excl, rsp.valid, !(rsp.inserted && (rsp.found || rsp.table_full)), "inserted with found or full")
  `OAHT_ASSERT_NEXT(a_count_hold, state != ST_CHECK, used_count == $past(used_count), "count changed outside probe check")

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the open-address hash table
`timescale 1ns / 1ps

module testbench;
  import oaht_pkg::*;

  localparam int SLOTS       = 256;
  localparam int POOL_DEPTH  = 320;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic        found;
    logic        inserted;
    logic        table_full;
    logic [7:0]  slot_index;
    logic [31:0] read_value;
    logic [8:0]  entry_count;
  } outcome_t;

  typedef struct {
    action_t     act;
    logic [31:0] key;
    logic [31:0] key_hash;
    logic [31:0] wval;
    bit          typed;
    outcome_t    want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [COUNT_BITS-1:0] cfg_wdata = '0;

  oaht_req_if req ();
  oaht_rsp_if rsp ();

  open_address_hash_table dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .req(req), .rsp(rsp)
  );

  // Shadow copy of the table contents
  mark_t       mirror_mark [SLOTS];
  logic [6:0]  mirror_fp   [SLOTS];
  logic [31:0] mirror_key  [SLOTS];
  logic [31:0] mirror_val  [SLOTS];
  int unsigned mirror_used;
  int unsigned mirror_limit;

  outcome_t    pending_outcomes [$];
  int unsigned error_count = 0;
  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;

  logic [31:0] pool_key  [POOL_DEPTH];
  logic [31:0] pool_hash [POOL_DEPTH];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch at word %0d: %s got %0h want %0h", words_checked, what, got, want);
    error_count++;
  endtask

  // Probe the shadow table and apply one word, return its outcome
  function automatic outcome_t table_apply(action_t act, logic [31:0] key,
                                           logic [31:0] key_hash, logic [31:0] wval);
    outcome_t    res;
    logic [6:0]  fp;
    logic [7:0]  pos;
    logic [7:0]  hit_slot;
    logic [7:0]  free_slot;
    logic [7:0]  tomb_slot;
    bit          hit;
    bit          have_free;
    bit          tomb_seen;
    int unsigned cap;
    res = '0;
    fp = key_hash[31:25];
    pos = key_hash[7:0];
    hit = 0;
    have_free = 0;
    tomb_seen = 0;
    hit_slot = '0;
    free_slot = '0;
    tomb_slot = '0;
    cap = (mirror_limit < SLOTS) ? mirror_limit : SLOTS;
    if (act == ACT_PUT || ((act == ACT_LOOKUP || act == ACT_REMOVE) && mirror_used != 0)) begin
      for (int n = 0; n < SLOTS; n++) begin
        if (mirror_mark[pos] == MARK_OPEN) begin
          have_free = 1;
          free_slot = pos;
          break;
        end
        if (mirror_mark[pos] == MARK_USED) begin
          if (mirror_fp[pos] == fp && mirror_key[pos] == key) begin
            hit = 1;
            hit_slot = pos;
            break;
          end
        end else if (!tomb_seen) begin
          tomb_seen = 1;
          tomb_slot = pos;
        end
        pos = pos + 8'd1;
      end
      if (!hit && tomb_seen) begin
        have_free = 1;
        free_slot = tomb_slot;
      end
    end
    case (act)
      ACT_LOOKUP: begin
        if (hit) begin
          res.found = 1'b1;
          res.slot_index = hit_slot;
          res.read_value = mirror_val[hit_slot];
        end
      end
      ACT_PUT: begin
        if (hit) begin
          mirror_val[hit_slot] = wval;
          res.found = 1'b1;
          res.slot_index = hit_slot;
        end else if (mirror_used >= cap || !have_free) begin
          res.table_full = 1'b1;
        end else begin
          mirror_mark[free_slot] = MARK_USED;
          mirror_fp[free_slot] = fp;
          mirror_key[free_slot] = key;
          mirror_val[free_slot] = wval;
          mirror_used++;
          res.inserted = 1'b1;
          res.slot_index = free_slot;
        end
      end
      ACT_REMOVE: begin
        if (hit) begin
          mirror_mark[hit_slot] = MARK_TOMB;
          mirror_used--;
          res.found = 1'b1;
          res.slot_index = hit_slot;
        end
      end
      default: ;
    endcase
    res.entry_count = mirror_used[8:0];
    return res;
  endfunction

  // Present one word and hold it until accepted; valid stays high for a following word
  task automatic send_word(input action_t act, input logic [31:0] key,
                           input logic [31:0] key_hash, input logic [31:0] wval,
                           input bit typed, input outcome_t want);
    outcome_t predicted;
    req.valid <= 1'b1;
    req.action <= act;
    req.key <= key;
    req.key_hash <= key_hash;
    req.write_value <= wval;
    do @(posedge clk); while (!req.ready);
    predicted = table_apply(act, key, key_hash, wval);
    pending_outcomes.push_back(typed ? want : predicted);
    words_sent++;
  endtask

  // Insert a random gap between bursts
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_limit(input int unsigned value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value[8:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    mirror_limit = value;
    @(posedge clk);
  endtask

  // Random words drawn mostly from a key pool so hits, overwrites and tombstones occur
  task automatic random_words(input int count, input int pool_size, input bit hold_once);
    action_t     act;
    logic [31:0] key;
    logic [31:0] key_hash;
    int          pick;
    int          idx;
    for (int i = 0; i < count; i++) begin
      if (hold_once && i == count / 2) drain();
      pace();
      idx = $urandom_range(0, pool_size - 1);
      key = pool_key[idx];
      key_hash = pool_hash[idx];
      if ($urandom_range(0, 15) == 0) key_hash = $urandom;
      if ($urandom_range(0, 31) == 0) key = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 35) act = ACT_LOOKUP;
      else if (pick < 75) act = ACT_PUT;
      else if (pick < 95) act = ACT_REMOVE;
      else act = ACT_NONE;
      send_word(act, key, key_hash, $urandom, 1'b0, '0);
    end
  endtask

  // Receiver stall pattern: runs of always-ready alternate with random stalls
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (cycle_count[9]) begin
      rsp.ready <= 1'b1;
    end else begin
      rsp.ready <= ($urandom_range(0, 2) != 0);
    end
  end

  // Compare each result word with the oldest expectation
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_outcomes.size() == 0) begin
        $display("unexpected result word at cycle %0d", cycle_count);
        error_count++;
      end else begin
        want = pending_outcomes.pop_front();
        if (rsp.found !== want.found)
          report("found", 32'(rsp.found), 32'(want.found));
        if (rsp.inserted !== want.inserted)
          report("inserted", 32'(rsp.inserted), 32'(want.inserted));
        if (rsp.table_full !== want.table_full)
          report("table_full", 32'(rsp.table_full), 32'(want.table_full));
        if (rsp.slot_index !== want.slot_index)
          report("slot_index", 32'(rsp.slot_index), 32'(want.slot_index));
        if (rsp.read_value !== want.read_value)
          report("read_value", rsp.read_value, want.read_value);
        if (rsp.entry_count !== want.entry_count)
          report("entry_count", 32'(rsp.entry_count), 32'(want.entry_count));
      end
      words_checked++;
    end
  end

  // Directed words; typed rows carry an expectation read straight off the behavior
  stim_row_t directed [] = '{
    '{ACT_LOOKUP, 32'd5, 32'd5, 32'd0, 1'b1, '{0, 0, 0, 8'd0, 32'd0, 9'd0}},
    '{ACT_REMOVE, 32'd5, 32'd5, 32'd0, 1'b1, '{0, 0, 0, 8'd0, 32'd0, 9'd0}},
    '{ACT_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1,
      '{0, 0, 0, 8'd0, 32'd0, 9'd0}},
    '{ACT_PUT, 32'd0, 32'd0, 32'hFFFFFFFF, 1'b1, '{0, 1, 0, 8'd0, 32'd0, 9'd1}},
    '{ACT_PUT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0, 1'b1, '{0, 1, 0, 8'd255, 32'd0, 9'd2}},
    '{ACT_LOOKUP, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0, 1'b1,
      '{1, 0, 0, 8'd255, 32'd0, 9'd2}},
    '{ACT_LOOKUP, 32'd0, 32'd0, 32'd0, 1'b1, '{1, 0, 0, 8'd0, 32'hFFFFFFFF, 9'd2}},
    '{ACT_PUT, 32'd0, 32'd0, 32'h12345678, 1'b1, '{1, 0, 0, 8'd0, 32'd0, 9'd2}},
    '{ACT_PUT, 32'd7, 32'h000000FF, 32'hA5A5A5A5, 1'b0, '0},
    '{ACT_LOOKUP, 32'd0, 32'h80000000, 32'd0, 1'b0, '0},
    '{ACT_REMOVE, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0, 1'b1, '{1, 0, 0, 8'd255, 32'd0, 9'd2}},
    '{ACT_LOOKUP, 32'd7, 32'h000000FF, 32'd0, 1'b0, '0},
    '{ACT_PUT, 32'd9, 32'h000000FF, 32'h5A5A5A5A, 1'b0, '0},
    '{ACT_REMOVE, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0, 1'b0, '0},
    '{ACT_PUT, 32'h0000FFFF, 32'hFFFF0001, 32'hFFFF0000, 1'b0, '0},
    '{ACT_LOOKUP, 32'h0000FFFF, 32'hFFFF0001, 32'd0, 1'b0, '0},
    '{ACT_REMOVE, 32'd7, 32'h000000FF, 32'd0, 1'b0, '0},
    '{ACT_LOOKUP, 32'd9, 32'h000000FF, 32'd0, 1'b0, '0},
    '{ACT_NONE, 32'd1, 32'd1, 32'd1, 1'b0, '0}
  };

  initial begin
    req.valid = 1'b0;
    req.action = ACT_LOOKUP;
    req.key = '0;
    req.key_hash = '0;
    req.write_value = '0;
    for (int s = 0; s < SLOTS; s++) begin
      mirror_mark[s] = MARK_OPEN;
      mirror_fp[s] = '0;
      mirror_key[s] = '0;
      mirror_val[s] = '0;
    end
    mirror_used = 0;
    mirror_limit = LIMIT_RESET;
    // Cluster about half the pool hashes into home slots 0 to 15 to build long probe runs
    for (int p = 0; p < POOL_DEPTH; p++) begin
      pool_key[p] = $urandom;
      pool_hash[p] = $urandom;
      if ($urandom_range(0, 1) == 0) pool_hash[p][7:0] = $urandom_range(0, 15);
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      pace();
      send_word(directed[i].act, directed[i].key, directed[i].key_hash, directed[i].wval,
                directed[i].typed, directed[i].want);
    end

    // Limit zero refuses every new key but still overwrites
    set_limit(0);
    send_word(ACT_PUT, 32'hCAFE0001, 32'h00000040, 32'd3, 1'b1,
              '{0, 0, 1, 8'd0, 32'd0, mirror_used[8:0]});
    send_word(ACT_PUT, 32'd0, 32'd0, 32'd77, 1'b0, '0);
    random_words(6, 16, 1'b0);
    set_limit(1);
    random_words(40, 16, 1'b0);
    set_limit(20);
    random_words(300, 40, 1'b1);
    set_limit(511);
    random_words(500, 320, 1'b0);
    set_limit(256);
    random_words(300, 64, 1'b0);
    set_limit(300);
    random_words(200, 24, 1'b0);

    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d words over limits 256, 0, 1, 20, 511, 256, 300", words_sent);
    $display("checked %0d result words, table ended with %0d entries", words_checked,
             mirror_used);
    if (error_count == 0 && pending_outcomes.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
